### rtl/rpfc_pkg.sv
// Shared types and constants for the RGB pixel format converter.
// No dependencies; compiled first.
package rpfc_pkg;

    localparam int PIX_W       = 32;
    localparam int CHAN_W      = 16;
    localparam int SHIFT_W     = 5;
    localparam int NUM_CHAN    = 3;
    localparam int MAXIMA_W    = CHAN_W * NUM_CHAN;
    localparam int SHIFTS_W    = SHIFT_W * NUM_CHAN;
    localparam int BYTES_W     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;

    // Divider: CHAN_W quotient bits spread over DIV_STAGES stages.
    localparam int DIV_STAGES   = 4;
    localparam int DIV_BITS     = CHAN_W / DIV_STAGES;
    // extract + multiply + divider stages + output register
    localparam int NUM_STAGES   = DIV_STAGES + 3;

    typedef logic [NUM_STAGES-1:0] stage_vec_t;

    typedef enum logic [1:0] {
        MODE_PASS   = 2'd0,
        MODE_FROM16 = 2'd1,
        MODE_FROM32 = 2'd2
    } mode_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE      = 3'd0,
        REG_SRC_MAX   = 3'd1,
        REG_SRC_SHIFT = 3'd2,
        REG_DST_MAX   = 3'd3,
        REG_DST_SHIFT = 3'd4,
        REG_DST_BYTES = 3'd5
    } reg_idx_e;

    localparam logic [BYTES_W-1:0] DST_BYTES_1 = 3'd1;
    localparam logic [BYTES_W-1:0] DST_BYTES_2 = 3'd2;
    localparam logic [BYTES_W-1:0] DST_BYTES_4 = 3'd4;

    typedef struct packed {
        logic [1:0]          mode;
        logic [MAXIMA_W-1:0] src_max;
        logic [SHIFTS_W-1:0] src_shift;
        logic [MAXIMA_W-1:0] dst_max;
        logic [SHIFTS_W-1:0] dst_shift;
        logic [BYTES_W-1:0]  dst_bytes;
    } cfg_t;

endpackage

### rtl/rpfc_if.sv
// Handshake interfaces: source pixel, converted pixel and register write beats.
// Depends on rpfc_pkg.
interface rpfc_src_if;
    logic                       valid;
    logic                       ready;
    logic [rpfc_pkg::PIX_W-1:0] source_pixel;
    modport source (output valid, output source_pixel, input ready);
    modport sink   (input valid, input source_pixel, output ready);
endinterface

interface rpfc_dst_if;
    logic                       valid;
    logic                       ready;
    logic [rpfc_pkg::PIX_W-1:0] converted_pixel;
    modport source (output valid, output converted_pixel, input ready);
    modport sink   (input valid, input converted_pixel, output ready);
endinterface

interface rpfc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rpfc_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [rpfc_pkg::CFG_DATA_W-1:0] wdata;
    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

### rtl/rpfc_cfg_regs.sv
// Configuration register file, written one beat at a time.
// Depends on rpfc_pkg and rpfc_cfg_if.
module rpfc_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    rpfc_cfg_if.sink        cfg,
    output rpfc_pkg::cfg_t  regs
);

    rpfc_pkg::cfg_t cfg_reg;
    rpfc_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                rpfc_pkg::REG_MODE:      cfg_next.mode      = cfg.wdata[1:0];
                rpfc_pkg::REG_SRC_MAX:   cfg_next.src_max   = cfg.wdata[rpfc_pkg::MAXIMA_W-1:0];
                rpfc_pkg::REG_SRC_SHIFT: cfg_next.src_shift = cfg.wdata[rpfc_pkg::SHIFTS_W-1:0];
                rpfc_pkg::REG_DST_MAX:   cfg_next.dst_max   = cfg.wdata[rpfc_pkg::MAXIMA_W-1:0];
                rpfc_pkg::REG_DST_SHIFT: cfg_next.dst_shift = cfg.wdata[rpfc_pkg::SHIFTS_W-1:0];
                rpfc_pkg::REG_DST_BYTES: cfg_next.dst_bytes = cfg.wdata[rpfc_pkg::BYTES_W-1:0];
                default:                 cfg_next = cfg_reg; // unmapped index: dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{mode:      rpfc_pkg::MODE_PASS,
                         src_max:   '0,
                         src_shift: '0,
                         dst_max:   '0,
                         dst_shift: '0,
                         dst_bytes: rpfc_pkg::DST_BYTES_4};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/rpfc_pipe_ctrl.sv
// Valid bits and per-stage load enables for the conversion pipeline.
// Depends on rpfc_pkg.
module rpfc_pipe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 out_ready,
    output logic                 out_valid,
    output rpfc_pkg::stage_vec_t load
);

    localparam int N = rpfc_pkg::NUM_STAGES;

    rpfc_pkg::stage_vec_t valid_reg;
    rpfc_pkg::stage_vec_t valid_next;

    // A stage loads when it is empty or its contents move on.
    always_comb
    begin
        load[N-1] = !valid_reg[N-1] || out_ready;
        for (int k = N - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < N; k++)
        begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[N-1];

endmodule

### rtl/rpfc_div_stage.sv
// One stage of the restoring divider: DIV_BITS quotient bits per stage.
// Depends on rpfc_pkg.
module rpfc_div_stage (
    input  logic                        clk,
    input  logic                        load,
    input  logic [rpfc_pkg::CHAN_W-1:0] divisor,
    input  logic [rpfc_pkg::CHAN_W-1:0] rem_in,
    input  logic [rpfc_pkg::CHAN_W-1:0] bits_in,
    output logic [rpfc_pkg::CHAN_W-1:0] rem_out,
    output logic [rpfc_pkg::CHAN_W-1:0] bits_out
);

    localparam int W = rpfc_pkg::CHAN_W;

    logic [W-1:0] rem_reg,  rem_next;
    logic [W-1:0] bits_reg, bits_next;
    logic [W:0]   trial;

    // bits holds dividend bits still to shift in (top) and quotient bits (bottom).
    // rem < divisor on entry, so the trial never needs more than W+1 bits.
    always_comb
    begin
        rem_next  = rem_in;
        bits_next = bits_in;
        trial     = '0;
        for (int i = 0; i < rpfc_pkg::DIV_BITS; i++)
        begin
            trial     = {rem_next, bits_next[W-1]};
            bits_next = {bits_next[W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                trial        = trial - {1'b0, divisor};
                bits_next[0] = 1'b1;
            end
            rem_next = trial[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg  <= rem_next;
            bits_reg <= bits_next;
        end
    end

    assign rem_out  = rem_reg;
    assign bits_out = bits_reg;

endmodule

### rtl/rpfc_chan_lane.sv
// One color channel: extract, multiply by destination max, divide by source max.
// Depends on rpfc_pkg and rpfc_div_stage.
module rpfc_chan_lane (
    input  logic                         clk,
    input  rpfc_pkg::stage_vec_t         load,
    input  logic [rpfc_pkg::PIX_W-1:0]   pixel,
    input  logic [rpfc_pkg::SHIFT_W-1:0] src_shift,
    input  logic [rpfc_pkg::CHAN_W-1:0]  src_max,
    input  logic [rpfc_pkg::CHAN_W-1:0]  dst_max,
    input  logic                         rounding,
    output logic [rpfc_pkg::CHAN_W-1:0]  scaled
);

    localparam int W  = rpfc_pkg::CHAN_W;
    localparam int DS = rpfc_pkg::DIV_STAGES;
    // zero flag rides from the extract stage to the last divider stage
    localparam int ZN = DS + 2;

    logic [W-1:0]            value_reg;
    logic [ZN-1:0]           zero_reg;
    logic [2*W-1:0]          product;
    logic [W-1:0]            num_hi_reg, num_lo_reg;
    logic [W-1:0]            rem_chain  [DS+1];
    logic [W-1:0]            bits_chain [DS+1];
    logic [rpfc_pkg::PIX_W-1:0] shifted;

    // stage 1: extract
    assign shifted = pixel >> src_shift;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            value_reg <= shifted[W-1:0] & src_max;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ZN; k++)
        begin
            if (load[k])
            begin
                zero_reg[k] <= (k == 0) ? (src_max == '0) : zero_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // stage 2: numerator, below src_max * 2^16 so the quotient fits 16 bits
    assign product = value_reg * dst_max
                   + (rounding ? {{(W+1){1'b0}}, src_max[W-1:1]} : '0);

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            num_hi_reg <= product[2*W-1:W];
            num_lo_reg <= product[W-1:0];
        end
    end

    assign rem_chain[0]  = num_hi_reg;
    assign bits_chain[0] = num_lo_reg;

    // stages 3..: divider
    for (genvar g = 0; g < DS; g++)
    begin : g_div
        rpfc_div_stage u_div (
            .clk      (clk),
            .load     (load[g+2]),
            .divisor  (src_max),
            .rem_in   (rem_chain[g]),
            .bits_in  (bits_chain[g]),
            .rem_out  (rem_chain[g+1]),
            .bits_out (bits_chain[g+1])
        );
    end

    assign scaled = zero_reg[ZN-1] ? '0 : bits_chain[DS];

endmodule

### rtl/rgb_pixel_format_converter_unit.sv
// RGB pixel format converter, top level.
// Depends on rpfc_pkg, rpfc_if, rpfc_cfg_regs, rpfc_pipe_ctrl, rpfc_chan_lane.

// One pixel beat in, one converted pixel beat out, at one beat per clock
// sustained while dst takes beats. An accepted src beat passes channel
// extract, a 16x16 multiply, four divider stages of four quotient bits
// each, and the output register. The three channels run in parallel
// lanes; the divider pipeline sets the depth. The pipeline stalls stage by
// stage, so while dst is held off src keeps taking beats until every stage
// is full. Registers are written through cfg (always ready) and must only
// change while no pixel is in flight. Mode 0 passes the pixel untouched,
// mode 1 converts the low 16 bits with truncating scale, mode 2 converts
// 32 bits with rounded scale; mode 3 and a destination size other than
// 1, 2 or 4 bytes give zero. A channel with source max zero gives zero.
module rgb_pixel_format_converter_unit (
    input  logic       clk,
    input  logic       rst_n,
    rpfc_src_if.sink   src,
    rpfc_dst_if.source dst,
    rpfc_cfg_if.sink   cfg
);

    localparam int N  = rpfc_pkg::NUM_STAGES;
    localparam int W  = rpfc_pkg::CHAN_W;
    localparam int SW = rpfc_pkg::SHIFT_W;
    localparam int PW = rpfc_pkg::PIX_W;
    localparam int NC = rpfc_pkg::NUM_CHAN;

    rpfc_pkg::cfg_t       regs;
    rpfc_pkg::stage_vec_t load;

    logic [PW-1:0] pix_in;
    logic [PW-1:0] pix_reg [N-1];
    logic [W-1:0]  scaled  [NC];
    logic [PW-1:0] packed_pix;
    logic [PW-1:0] out_next, out_reg;
    logic          rounding;

    rpfc_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    rpfc_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (src.valid),
        .in_ready  (src.ready),
        .out_ready (dst.ready),
        .out_valid (dst.valid),
        .load      (load)
    );

    // 16-bit sources only see the low half
    assign pix_in = (regs.mode == rpfc_pkg::MODE_FROM16)
                  ? {{(PW-16){1'b0}}, src.source_pixel[15:0]}
                  : src.source_pixel;

    assign rounding = (regs.mode == rpfc_pkg::MODE_FROM32);

    // raw pixel rides along for pass-through
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N - 1; k++)
        begin
            if (load[k])
            begin
                pix_reg[k] <= (k == 0) ? pix_in : pix_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // lane 0 blue, 1 green, 2 red
    for (genvar c = 0; c < NC; c++)
    begin : g_lane
        rpfc_chan_lane u_lane (
            .clk       (clk),
            .load      (load),
            .pixel     (pix_in),
            .src_shift (regs.src_shift[c*SW +: SW]),
            .src_max   (regs.src_max[c*W +: W]),
            .dst_max   (regs.dst_max[c*W +: W]),
            .rounding  (rounding),
            .scaled    (scaled[c])
        );
    end

    // position channels; bits pushed past bit 31 drop out
    always_comb
    begin
        packed_pix = '0;
        for (int c = 0; c < NC; c++)
        begin
            packed_pix = packed_pix
                       | ({{(PW-W){1'b0}}, scaled[c]} << regs.dst_shift[c*SW +: SW]);
        end
    end

    always_comb
    begin
        out_next = '0;
        unique case (regs.mode)
            rpfc_pkg::MODE_PASS:
                out_next = pix_reg[N-2];
            rpfc_pkg::MODE_FROM16,
            rpfc_pkg::MODE_FROM32:
            begin
                unique case (regs.dst_bytes)
                    rpfc_pkg::DST_BYTES_4: out_next = packed_pix;
                    rpfc_pkg::DST_BYTES_2: out_next = {{(PW-16){1'b0}}, packed_pix[15:0]};
                    rpfc_pkg::DST_BYTES_1: out_next = {{(PW-8){1'b0}}, packed_pix[7:0]};
                    default:               out_next = '0;
                endcase
            end
            default:
                out_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load[N-1])
        begin
            out_reg <= out_next;
        end
    end

    assign dst.converted_pixel = out_reg;

endmodule

### rtl/rpfc_checker.sv
// Port-level checks for the converter, bound to the top level.
// Depends on rgb_pixel_format_converter_unit and its interfaces.
module rpfc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       src_ready,
    input logic                       dst_valid,
    input logic                       dst_ready,
    input logic [rpfc_pkg::PIX_W-1:0] dst_pixel,
    input logic                       cfg_ready
);

    // a stalled beat stays offered
    a_dst_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_ready |=> dst_valid)
        else $error("dst beat dropped while stalled");

    a_dst_stable: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_ready |=> $stable(dst_pixel))
        else $error("dst payload changed while stalled");

    // with the output free, the pipe must take a new beat
    a_src_ready: assert property (@(posedge clk) disable iff (!rst_n)
        dst_ready || !dst_valid |-> src_ready)
        else $error("src held off with free output");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("register port not ready");

endmodule

bind rgb_pixel_format_converter_unit rpfc_checker u_rpfc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_ready (src.ready),
    .dst_valid (dst.valid),
    .dst_ready (dst.ready),
    .dst_pixel (dst.converted_pixel),
    .cfg_ready (cfg.ready)
);
